@@ hw/rtl/smpm_pkg.sv @@
package smpm_pkg;

    localparam int MAX_CHANNELS_DEF = 65536;

    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_W      = 16;
    localparam int START_W    = 17;
    localparam int DIV_N_W    = 32;
    localparam int DIV_D_W    = 16;
    localparam int RECIP_W    = DIV_N_W + 1;
    localparam int INCH_W     = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHANNEL      = 3'd0,
        CFG_CHANNEL_COUNT      = 3'd1,
        CFG_STRING_COUNT       = 3'd2,
        CFG_STRANDS_PER_STRING = 3'd3,
        CFG_VERTICAL           = 3'd4,
        CFG_TOP_TO_BOTTOM      = 3'd5,
        CFG_LEFT_TO_RIGHT      = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_MAPPED   = 2'd0,
        ST_IDENTITY = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        LY_IDLE,
        LY_PIX,
        LY_SIZE,
        LY_DIM,
        LY_OTHER,
        LY_RECIP
    } layout_state_t;

    typedef struct packed {
        logic               go;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hw/rtl/smpm_div.sv @@
module smpm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  smpm_pkg::div_req_t req,
    output smpm_pkg::div_rsp_t rsp
);
    import smpm_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dsr_reg;

    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   diff;
    logic               ge;
    logic [DIV_D_W-1:0] rem_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_N_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.go)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_N_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        rsp.done      = done_reg;
        rsp.quotient  = quo_reg;
    end

endmodule

@@ hw/rtl/serpentine_matrix_pixel_mapper.sv @@
// an accepted request passes through stage 1, stage 2 and stage 3 to its done strobe
// throughput: one request per cycle while busy is low, results leave with no back pressure
// a configuration write holds busy while the shared bit-serial divider
// derives the layout in up to four divisions
// reset is asynchronous and active low; it restores the register defaults,
// clears width, height and layout valid, and empties the pipeline
module serpentine_matrix_pixel_mapper #(
    parameter int MAX_CHANNELS = smpm_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smpm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [smpm_pkg::DIM_W-1:0]      row,
    input  logic [smpm_pkg::DIM_W-1:0]      col,
    output logic                            done,
    output logic [smpm_pkg::DIM_W-1:0]      in_channel,
    output logic [smpm_pkg::DIM_W-1:0]      out_channel,
    output logic [1:0]                      status
);
    import smpm_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = ((IDX_W > INCH_W) ? IDX_W : INCH_W) + 1;
    localparam int PROD_W = DIM_W + RECIP_W;
    localparam logic [DIM_W-1:0] THIRD_RECIP = 16'hAAAB;

    // configuration registers
    logic [START_W-1:0] start_channel_reg;
    logic [DIM_W-1:0]   channel_count_reg;
    logic [DIM_W-1:0]   string_count_reg;
    logic [DIM_W-1:0]   strands_reg;
    logic               vertical_reg;
    logic               top_to_bottom_reg;
    logic               left_to_right_reg;
    logic               restart_reg;

    // derived layout
    layout_state_t      state_reg, state_next;
    logic [DIM_W-1:0]   pixels_reg, pixels_next;
    logic [DIM_W-1:0]   dim_reg, dim_next;
    logic [DIM_W-1:0]   model_width_reg, model_width_next;
    logic [DIM_W-1:0]   model_height_reg, model_height_next;
    logic               layout_valid_reg, layout_valid_next;
    logic [RECIP_W-1:0] recip_reg, recip_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [2*DIM_W-1:0] third_prod;
    logic [DIM_W:0]     pix_times3;
    logic [DIM_W-1:0]   strings_min;
    logic               pix_bad;
    logic [START_W-1:0] base;
    logic               accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_channel_reg <= START_W'(1);
            channel_count_reg <= '0;
            string_count_reg  <= '0;
            strands_reg       <= '0;
            vertical_reg      <= 1'b0;
            top_to_bottom_reg <= 1'b0;
            left_to_right_reg <= 1'b0;
            restart_reg       <= 1'b0;
        end
        else
        begin
            restart_reg <= 1'b0;
            if (cfg_we)
            begin
                restart_reg <= 1'b1;
                case (cfg_index)
                    CFG_START_CHANNEL:      start_channel_reg <= cfg_data;
                    CFG_CHANNEL_COUNT:      channel_count_reg <= cfg_data[DIM_W-1:0];
                    CFG_STRING_COUNT:       string_count_reg  <= cfg_data[DIM_W-1:0];
                    CFG_STRANDS_PER_STRING: strands_reg       <= cfg_data[DIM_W-1:0];
                    CFG_VERTICAL:           vertical_reg      <= cfg_data[0];
                    CFG_TOP_TO_BOTTOM:      top_to_bottom_reg <= cfg_data[0];
                    CFG_LEFT_TO_RIGHT:      left_to_right_reg <= cfg_data[0];
                    default:                restart_reg       <= 1'b0;
                endcase
            end
        end
    end

    assign base = (start_channel_reg == '0) ? '0 : start_channel_reg - START_W'(1);

    // pixels by reciprocal multiply, then checked against the channel count
    always_comb
    begin
        third_prod  = (2*DIM_W)'(channel_count_reg) * (2*DIM_W)'(THIRD_RECIP);
        pix_times3  = {pixels_reg, 1'b0} + {1'b0, pixels_reg};
        strings_min = (string_count_reg > pixels_reg) ? pixels_reg : string_count_reg;
        pix_bad     = (channel_count_reg == '0) || (strings_min == '0) ||
                      (strands_reg == '0) || (pix_times3 != {1'b0, channel_count_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        if (restart_reg)
        begin
            state_next = LY_PIX;
        end
        else if (state_reg == LY_PIX)
        begin
            state_next = pix_bad ? LY_IDLE : LY_SIZE;
        end
        else if (div_rsp.done)
        begin
            case (state_reg)
                LY_SIZE:  state_next = LY_DIM;
                LY_DIM:   state_next = (div_rsp.quotient == '0) ? LY_IDLE : LY_OTHER;
                LY_OTHER: state_next = LY_RECIP;
                LY_RECIP: state_next = LY_IDLE;
                default:  state_next = LY_IDLE;
            endcase
        end
    end

    always_comb
    begin
        div_req.go        = 1'b0;
        div_req.dividend  = '0;
        div_req.divisor   = '0;
        pixels_next       = pixels_reg;
        dim_next          = dim_reg;
        model_width_next  = model_width_reg;
        model_height_next = model_height_reg;
        layout_valid_next = layout_valid_reg;
        recip_next        = recip_reg;

        if (restart_reg)
        begin
            pixels_next       = DIM_W'(third_prod[2*DIM_W-1:DIM_W+1]);
            layout_valid_next = 1'b0;
        end
        else if (state_reg == LY_PIX)
        begin
            div_req.go       = !pix_bad;
            div_req.dividend = DIV_N_W'(pixels_reg);
            div_req.divisor  = strings_min;
        end
        else if (div_rsp.done)
        begin
            case (state_reg)
                LY_SIZE:
                begin
                    div_req.go       = 1'b1;
                    div_req.dividend = DIV_N_W'(div_rsp.quotient[DIM_W-1:0]);
                    div_req.divisor  = strands_reg;
                end
                LY_DIM:
                begin
                    dim_next         = div_rsp.quotient[DIM_W-1:0];
                    div_req.go       = (div_rsp.quotient != '0);
                    div_req.dividend = DIV_N_W'(pixels_reg);
                    div_req.divisor  = div_rsp.quotient[DIM_W-1:0];
                end
                LY_OTHER:
                begin
                    div_req.go       = 1'b1;
                    div_req.dividend = '1;
                    div_req.divisor  = strands_reg;
                    if (vertical_reg)
                    begin
                        model_width_next  = div_rsp.quotient[DIM_W-1:0];
                        model_height_next = dim_reg;
                    end
                    else
                    begin
                        model_width_next  = dim_reg;
                        model_height_next = div_rsp.quotient[DIM_W-1:0];
                    end
                end
                LY_RECIP:
                begin
                    // ceiling reciprocal, exact quotients for 16-bit values
                    recip_next        = RECIP_W'(div_rsp.quotient) + RECIP_W'(1);
                    layout_valid_next = 1'b1;
                end
                default:
                begin
                    layout_valid_next = layout_valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= LY_IDLE;
            model_width_reg  <= '0;
            model_height_reg <= '0;
            layout_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            model_width_reg  <= model_width_next;
            model_height_reg <= model_height_next;
            layout_valid_reg <= layout_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixels_reg <= pixels_next;
        dim_reg    <= dim_next;
        recip_reg  <= recip_next;
    end

    smpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy   = cfg_we || restart_reg || (state_reg != LY_IDLE);
    assign accept = start && !busy;

    // stage 1: range flags, row times width, quotient parity
    logic               s1_valid_reg;
    logic [DIM_W-1:0]   s1_x_reg;
    logic [DIM_W-1:0]   s1_y_reg;
    logic [DIM_W-1:0]   s1_yw_reg;
    logic               s1_q0_reg;
    logic               s1_in_reg;

    logic [DIM_W-1:0]   coord;
    logic [PROD_W-1:0]  recip_prod;
    logic [2*DIM_W-1:0] yw_prod;

    always_comb
    begin
        coord      = vertical_reg ? col : row;
        recip_prod = PROD_W'(coord) * PROD_W'(recip_reg);
        yw_prod    = (2*DIM_W)'(row) * (2*DIM_W)'(model_width_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg  <= col;
        s1_y_reg  <= row;
        s1_yw_reg <= yw_prod[DIM_W-1:0];
        s1_q0_reg <= recip_prod[DIV_N_W];
        s1_in_reg <= (col < model_width_reg) && (row < model_height_reg);
    end

    // stage 2: serpentine fold, channel of the raster position
    logic               s2_valid_reg;
    status_t            s2_status_reg;
    logic [DIM_W-1:0]   s2_inch_reg;
    logic [DIM_W-1:0]   s2_prod_reg;
    logic [DIM_W-1:0]   s2_add_reg;

    logic               odd;
    logic [DIM_W-1:0]   x_rev;
    logic [DIM_W-1:0]   y_rev;
    logic [DIM_W-1:0]   mul_a;
    logic [DIM_W-1:0]   mul_b;
    logic [DIM_W-1:0]   mul_add;
    logic [2*DIM_W-1:0] mul_prod;
    logic [DIM_W:0]     linear;
    logic [INCH_W-1:0]  inch_full;
    logic [CMP_W-1:0]   inch_last;
    logic [DIM_W-1:0]   ident;
    status_t            status_s2;
    logic [DIM_W-1:0]   inch_s2;

    always_comb
    begin
        // parity of coord mod strands: coord minus q times strands
        odd   = (vertical_reg ? s1_x_reg[0] : s1_y_reg[0]) ^ (s1_q0_reg & strands_reg[0]);
        x_rev = model_width_reg - s1_x_reg - DIM_W'(1);
        y_rev = model_height_reg - s1_y_reg - DIM_W'(1);
        if (vertical_reg)
        begin
            mul_a   = left_to_right_reg ? s1_x_reg : x_rev;
            mul_b   = model_height_reg;
            mul_add = (top_to_bottom_reg != (odd != left_to_right_reg)) ? y_rev : s1_y_reg;
        end
        else
        begin
            mul_a   = top_to_bottom_reg ? s1_y_reg : y_rev;
            mul_b   = model_width_reg;
            mul_add = (left_to_right_reg != (odd != top_to_bottom_reg)) ? x_rev : s1_x_reg;
        end
        mul_prod  = (2*DIM_W)'(mul_a) * (2*DIM_W)'(mul_b);

        linear    = {1'b0, s1_yw_reg} + {1'b0, s1_x_reg};
        inch_full = INCH_W'(base) + INCH_W'({linear, 1'b0}) + INCH_W'(linear);
        inch_last = CMP_W'(inch_full) + CMP_W'(2);
        ident     = base[DIM_W-1:0] + {s1_x_reg[DIM_W-2:0], 1'b0} + s1_x_reg;

        if (!layout_valid_reg)
        begin
            status_s2 = ST_IDENTITY;
            inch_s2   = ident;
        end
        else if (!s1_in_reg || (inch_last >= CMP_W'(MAX_CHANNELS)))
        begin
            status_s2 = ST_RANGE;
            inch_s2   = '0;
        end
        else
        begin
            status_s2 = ST_MAPPED;
            inch_s2   = inch_full[DIM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_status_reg <= status_s2;
        s2_inch_reg   <= inch_s2;
        s2_prod_reg   <= mul_prod[DIM_W-1:0];
        s2_add_reg    <= mul_add;
    end

    // stage 3: physical channel and result register
    logic               done_reg;
    logic [DIM_W-1:0]   in_channel_reg;
    logic [DIM_W-1:0]   out_channel_reg;
    status_t            status_reg;

    logic [DIM_W-1:0]   mpos;
    logic [DIM_W-1:0]   outch;
    logic [DIM_W-1:0]   out_s3;

    always_comb
    begin
        mpos  = s2_prod_reg + s2_add_reg;
        outch = base[DIM_W-1:0] + {mpos[DIM_W-2:0], 1'b0} + mpos;
        case (s2_status_reg)
            ST_MAPPED:   out_s3 = outch;
            ST_IDENTITY: out_s3 = s2_inch_reg;
            default:     out_s3 = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        in_channel_reg  <= s2_inch_reg;
        out_channel_reg <= out_s3;
        status_reg      <= s2_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    assign done        = done_reg;
    assign in_channel  = in_channel_reg;
    assign out_channel = out_channel_reg;
    assign status      = status_reg;

    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("request did not produce a result after three cycles");

    a_done_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching request");

    a_layout_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        layout_valid_reg |-> (model_width_reg != '0) && (model_height_reg != '0))
        else $error("valid layout with zero width or height");

    a_mapped_needs_layout: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_MAPPED)) |-> layout_valid_reg)
        else $error("mapped result without a valid layout");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import smpm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [DIM_W-1:0] in_ch;
        logic [DIM_W-1:0] out_ch;
        status_t          st;
    } pixel_map_t;

    class pixel_map_board;
        logic [START_W-1:0] start_ch;
        logic [DIM_W-1:0]   chan_cnt;
        logic [DIM_W-1:0]   str_cnt;
        logic [DIM_W-1:0]   strands;
        logic               vert;
        logic               top_first;
        logic               left_first;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic               layout_ok;
        pixel_map_t         expected_maps[$];
        int                 failures;

        function new();
            start_ch   = 1;
            chan_cnt   = 0;
            str_cnt    = 0;
            strands    = 0;
            vert       = 0;
            top_first  = 0;
            left_first = 0;
            failures   = 0;
            derive_layout();
        endfunction

        function void derive_layout();
            logic [63:0] pixels;
            logic [63:0] strings;
            logic [63:0] span;
            logic [63:0] w;
            logic [63:0] h;
            pixels    = 64'(chan_cnt) / 64'd3;
            strings   = 64'(str_cnt);
            width     = 0;
            height    = 0;
            layout_ok = 0;
            if (strings > pixels)
                strings = pixels;
            if (chan_cnt == 0 || strings == 0 || strands == 0 || chan_cnt % 3 != 0)
                return;
            span = pixels / strings;
            if (vert)
            begin
                h = span / 64'(strands);
                if (h == 0)
                    return;
                w = pixels / h;
            end
            else
            begin
                w = span / 64'(strands);
                if (w == 0)
                    return;
                h = pixels / w;
            end
            if (w == 0 || h == 0)
                return;
            width     = w[DIM_W-1:0];
            height    = h[DIM_W-1:0];
            layout_ok = 1;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_START_CHANNEL:      start_ch   = value;
                CFG_CHANNEL_COUNT:      chan_cnt   = value[DIM_W-1:0];
                CFG_STRING_COUNT:       str_cnt    = value[DIM_W-1:0];
                CFG_STRANDS_PER_STRING: strands    = value[DIM_W-1:0];
                CFG_VERTICAL:           vert       = value[0];
                CFG_TOP_TO_BOTTOM:      top_first  = value[0];
                CFG_LEFT_TO_RIGHT:      left_first = value[0];
                default:                return;
            endcase
            derive_layout();
        endfunction

        function void note_request(logic [DIM_W-1:0] y, logic [DIM_W-1:0] x);
            logic [63:0] base;
            logic [63:0] yy;
            logic [63:0] xx;
            logic [63:0] w;
            logic [63:0] h;
            logic [63:0] inch;
            logic [63:0] outch;
            logic [63:0] ox;
            logic [63:0] oy;
            logic [63:0] mpos;
            logic        odd;
            pixel_map_t  r;
            base = (start_ch != 0) ? 64'(start_ch) - 64'd1 : 64'd0;
            yy   = 64'(y);
            xx   = 64'(x);
            w    = 64'(width);
            h    = 64'(height);
            if (!layout_ok)
            begin
                inch     = base + 64'd3 * xx;
                r.in_ch  = inch[DIM_W-1:0];
                r.out_ch = inch[DIM_W-1:0];
                r.st     = ST_IDENTITY;
            end
            else
            begin
                inch = base + 64'd3 * (yy * w + xx);
                if (xx >= w || yy >= h || inch + 64'd2 >= 64'(MAX_CHANNELS_DEF))
                begin
                    r.in_ch  = 0;
                    r.out_ch = 0;
                    r.st     = ST_RANGE;
                end
                else
                begin
                    if (vert)
                    begin
                        odd  = ((xx % 64'(strands)) & 64'd1) != 64'd0;
                        ox   = left_first ? xx : w - xx - 64'd1;
                        oy   = (top_first != (odd != left_first)) ? h - yy - 64'd1 : yy;
                        mpos = ox * h + oy;
                    end
                    else
                    begin
                        odd  = ((yy % 64'(strands)) & 64'd1) != 64'd0;
                        ox   = (left_first != (odd != top_first)) ? w - xx - 64'd1 : xx;
                        oy   = top_first ? yy : h - yy - 64'd1;
                        mpos = oy * w + ox;
                    end
                    outch    = base + 64'd3 * mpos;
                    r.in_ch  = inch[DIM_W-1:0];
                    r.out_ch = outch[DIM_W-1:0];
                    r.st     = ST_MAPPED;
                end
            end
            expected_maps.push_back(r);
        endfunction

        function void check_result(logic [DIM_W-1:0] in_ch, logic [DIM_W-1:0] out_ch,
                                   logic [1:0] st);
            pixel_map_t e;
            if (expected_maps.size() == 0)
            begin
                $error("unexpected result in_channel %0d out_channel %0d status %0d",
                       in_ch, out_ch, st);
                failures++;
                return;
            end
            e = expected_maps.pop_front();
            if (in_ch !== e.in_ch)
            begin
                $error("in_channel expected %0d actual %0d", e.in_ch, in_ch);
                failures++;
            end
            if (out_ch !== e.out_ch)
            begin
                $error("out_channel expected %0d actual %0d", e.out_ch, out_ch);
                failures++;
            end
            if (st !== e.st)
            begin
                $error("status expected %0d actual %0d", e.st, st);
                failures++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    logic [DIM_W-1:0]      row;
    logic [DIM_W-1:0]      col;
    logic                  done;
    logic [DIM_W-1:0]      in_channel;
    logic [DIM_W-1:0]      out_channel;
    logic [1:0]            status;
    int                    cycle_count;

    pixel_map_board board = new();

    serpentine_matrix_pixel_mapper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .row         (row),
        .col         (col),
        .done        (done),
        .in_channel  (in_channel),
        .out_channel (out_channel),
        .status      (status)
    );

    initial
    begin
        clk = 0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(in_channel, out_channel, status);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.write_reg(idx, value);
        cfg_we <= 0;
        do @(posedge clk); while (busy);
    endtask

    // wait until every outstanding request has returned
    task automatic drain();
        start <= 0;
        while (board.expected_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_layout(logic [START_W-1:0] sc, logic [DIM_W-1:0] cc,
                                logic [DIM_W-1:0] sn, logic [DIM_W-1:0] sp,
                                logic v, logic t, logic l);
        drain();
        write_reg(CFG_START_CHANNEL, sc);
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(cc));
        write_reg(CFG_STRING_COUNT, CFG_DATA_W'(sn));
        write_reg(CFG_STRANDS_PER_STRING, CFG_DATA_W'(sp));
        write_reg(CFG_VERTICAL, CFG_DATA_W'(v));
        write_reg(CFG_TOP_TO_BOTTOM, CFG_DATA_W'(t));
        write_reg(CFG_LEFT_TO_RIGHT, CFG_DATA_W'(l));
    endtask

    // idle cycles ahead of the request, each with chance idle_pct in a hundred
    task automatic send_request(logic [DIM_W-1:0] y, logic [DIM_W-1:0] x, int idle_pct);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 0;
            row   <= DIM_W'($urandom);
            col   <= DIM_W'($urandom);
            @(posedge clk);
        end
        start <= 1;
        row   <= y;
        col   <= x;
        do @(posedge clk); while (busy);
        board.note_request(y, x);
    endtask

    task automatic random_layout();
        int                 kind;
        logic [START_W-1:0] sc;
        logic [DIM_W-1:0]   cc;
        logic [DIM_W-1:0]   sn;
        logic [DIM_W-1:0]   sp;
        kind = $urandom_range(99);
        case ($urandom_range(9))
            0:       sc = '0;
            1:       sc = 17'h1FFFF;
            2:       sc = 17'd65536;
            3:       sc = 17'd1;
            default: sc = START_W'($urandom_range(1, 60000));
        endcase
        if (kind < 70)
        begin
            cc = DIM_W'(3 * $urandom_range(1, 400));
            sn = DIM_W'($urandom_range(1, 6));
            sp = DIM_W'($urandom_range(1, 3));
        end
        else if (kind < 85)
        begin
            cc = DIM_W'($urandom);
            sn = DIM_W'($urandom);
            sp = ($urandom_range(0, 3) == 0) ? '0 : DIM_W'($urandom);
        end
        else
        begin
            cc = $urandom_range(1) ? 16'd65532 : 16'd65535;
            sn = $urandom_range(1) ? 16'd1 : 16'd65535;
            sp = $urandom_range(1) ? 16'd1 : 16'd65535;
        end
        apply_layout(sc, cc, sn, sp, 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic run_random(int count, int idle_pct);
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] x;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                random_layout();
            if (board.layout_ok && $urandom_range(9) != 0)
            begin
                y = DIM_W'($urandom_range(0, board.height));
                x = DIM_W'($urandom_range(0, board.width));
            end
            else
            begin
                y = DIM_W'($urandom);
                x = DIM_W'($urandom);
            end
            send_request(y, x, idle_pct);
        end
    endtask

    initial
    begin
        logic [2:0] combo;
        rst_n     = 0;
        cfg_we    = 0;
        cfg_index = 0;
        cfg_data  = 0;
        start     = 0;
        row       = 0;
        col       = 0;
        cycle_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // identity mapping straight out of reset
        send_request(16'h0000, 16'h0000, 0);
        send_request(16'hFFFF, 16'hFFFF, 0);
        send_request(16'h0000, 16'h5555, 0);
        send_request(16'hAAAA, 16'hAAAA, 0);

        // 4x4 matrix, two strings of two strands, every orientation; requests the far corner and row 1, column 0
        for (int c = 0; c < 8; c++)
        begin
            combo = 3'(c);
            apply_layout((c == 0) ? '0 : START_W'(c * 1000 + 1), 16'd48, 16'd2, 16'd2,
                         combo[2], combo[1], combo[0]);
            send_request(board.height - 16'd1, board.width - 16'd1, 0);
            send_request(16'd1, 16'd0, 0);
        end
        send_request(board.height, 16'd0, 0);
        send_request(16'd0, board.width, 0);

        // one long row whose last pixel runs past the channel space
        apply_layout(17'd100, 16'd65532, 16'd1, 16'd1, 1'b0, 1'b1, 1'b1);
        send_request(16'd0, 16'd21843, 0);
        send_request(16'd0, 16'd0, 0);

        run_random(200, 17);
        run_random(200, 53);
        run_random(200, 0);

        drain();
        if (board.failures == 0 && board.expected_maps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
